FILE: rtl/core/pirl_pkg.sv
// ---------------------------------------------------------------------------
// pirl_pkg: shared definitions for the single-wire link master
// Register map, command and drive codes, timing reset values, result beat.
// ---------------------------------------------------------------------------
package pirl_pkg;

   // Largest bit counts of one transaction.
   localparam int unsigned MaxReadBits  = 64;
   localparam int unsigned MaxWriteBits = 32;

   // Field widths.
   localparam int unsigned CountW = 7;
   localparam int unsigned WordW  = 32;
   localparam int unsigned ValueW = 64;
   localparam int unsigned TickW  = 16;

   // Configuration register indexes (byte address is four times the index).
   localparam logic [1:0] REG_READ_START = 2'd0;
   localparam logic [1:0] REG_READ_GAP   = 2'd1;
   localparam logic [1:0] REG_WRITE_HOLD = 2'd2;
   localparam logic [1:0] REG_WRITE_END  = 2'd3;

   // Reset values of the timing registers.
   localparam logic [9:0]  RST_READ_START = 10'd110;
   localparam logic [7:0]  RST_READ_GAP   = 8'd13;
   localparam logic [9:0]  RST_WRITE_HOLD = 10'd100;
   localparam logic [15:0] RST_WRITE_END  = 16'd1000;

   // Command codes of an input beat.
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;

   // Wire drive codes.
   localparam logic [1:0] DRV_REL  = 2'd0;
   localparam logic [1:0] DRV_LOW  = 2'd1;
   localparam logic [1:0] DRV_HIGH = 2'd2;

   // One result beat.
   typedef struct packed {
      logic [1:0]        line_drive;
      logic              busy_res;
      logic              done_res;
      logic [ValueW-1:0] read_value;
      logic [3:0]        byte_count;
   } pirl_rsp_type;

endpackage

FILE: rtl/core/pirl_rsp_buf.sv
// ---------------------------------------------------------------------------
// pirl_rsp_buf: result register with skid stage
// Holds result beats so the tick engine keeps accepting while the consumer
// stalls; the upstream stall comes straight from a flip-flop.
// ---------------------------------------------------------------------------
module pirl_rsp_buf
   import pirl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  pirl_rsp_type push_data,
   output logic         full,
   output logic         out_valid,
   output pirl_rsp_type out_data,
   input  logic         out_stall
);

   logic         main_valid_ff;
   logic         main_valid_in;
   pirl_rsp_type main_ff;
   pirl_rsp_type main_in;
   logic         skid_valid_ff;
   logic         skid_valid_in;
   pirl_rsp_type skid_ff;
   pirl_rsp_type skid_in;
   logic         drain;

   assign drain = main_valid_ff & ~out_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // No push can arrive while the skid stage is occupied.
         if (drain) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || drain) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (drain) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

`ifndef SYNTH
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid stage holds a beat while the result register is empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(main_valid_ff && out_stall))
      else $error("skid stage filled without a stalled result");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !out_stall |=> main_valid_ff && !skid_valid_ff)
      else $error("skid beat not moved into the result register");
`endif

endmodule

FILE: rtl/core/pir_single_wire_link_master.sv
// ---------------------------------------------------------------------------
// pir_single_wire_link_master: timed master for a single-wire PIR link
// Every input beat is one microsecond tick; the block sequences read and
// write transactions on the wire and returns one result beat per tick.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Content
//   req      in         req_valid/req_stall  mode, bit count, word, line level
//   rsp      out        rsp_valid/rsp_stall  drive, busy, done, value, bytes
//   csr      in/out     psel/penable/pready  four timing registers, 32-bit data
//
// One tick beat is taken in every cycle while req_stall is low. The tick's whole step (the start
// decode, one state machine transition and the shift) is a single pass of
// logic from the state registers into the result register; a beat's result
// is registered there (or in the skid stage while rsp stalls), then shown on rsp.
// Reset puts the sequencer idle and the timing registers at their defaults.
// A stalled result waits in the result register; one more beat fits in the
// skid stage, and only then is req_stall raised, straight from a flip-flop.
// ---------------------------------------------------------------------------
module pir_single_wire_link_master
   import pirl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [CountW-1:0]  req_bit_count,
   input  logic [WordW-1:0]   req_write_word,
   input  logic               req_line_in,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_line_drive,
   output logic               rsp_busy_res,
   output logic               rsp_done_res,
   output logic [ValueW-1:0]  rsp_read_value,
   output logic [3:0]         rsp_byte_count,

   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // Sequencer phases.
   localparam logic [3:0] PH_IDLE    = 4'd0;
   localparam logic [3:0] PH_R_START = 4'd1;
   localparam logic [3:0] PH_R_LOW   = 4'd2;
   localparam logic [3:0] PH_R_HIGH  = 4'd3;
   localparam logic [3:0] PH_R_SAMP  = 4'd4;
   localparam logic [3:0] PH_R_WAIT  = 4'd5;
   localparam logic [3:0] PH_R_END   = 4'd6;
   localparam logic [3:0] PH_W_LOW   = 4'd7;
   localparam logic [3:0] PH_W_HIGH  = 4'd8;
   localparam logic [3:0] PH_W_HOLD  = 4'd9;
   localparam logic [3:0] PH_W_END   = 4'd10;

   localparam logic [CountW-1:0] READ_CAP  = CountW'(MaxReadBits);
   localparam logic [CountW-1:0] WRITE_CAP = CountW'(MaxWriteBits);

   // Timing registers.
   logic [9:0]  read_start_ff;
   logic [7:0]  read_gap_ff;
   logic [9:0]  write_hold_ff;
   logic [15:0] write_end_ff;

   // Sequencer state.
   logic [3:0]        phase_ff,        phase_in;
   logic [TickW-1:0]  tick_left_ff,    tick_left_in;
   logic [CountW-1:0] bits_left_ff,    bits_left_in;
   logic [CountW-1:0] total_bits_ff,   total_bits_in;
   logic [ValueW-1:0] shift_word_ff,   shift_word_in;
   logic              first_sample_ff, first_sample_in;
   logic [WordW-1:0]  send_word_ff,    send_word_in;

   logic              req_accept;
   logic              csr_write;
   logic              buf_full;
   pirl_rsp_type      step_rsp;
   pirl_rsp_type      out_rsp;
   logic [CountW-1:0] bit_index;
   logic [7:0]        byte_sum;

   assign req_accept = req_valid & ~buf_full;
   assign req_stall  = buf_full;

   // ------------------------------------------------------------------
   // Configuration port: no wait states, writes decoded on the access
   // phase, reads return the register zero-extended.
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         read_start_ff <= RST_READ_START;
         read_gap_ff   <= RST_READ_GAP;
         write_hold_ff <= RST_WRITE_HOLD;
         write_end_ff  <= RST_WRITE_END;
      end else if (csr_write) begin
         case (paddr[3:2])
            REG_READ_START: read_start_ff <= pwdata[9:0];
            REG_READ_GAP:   read_gap_ff   <= pwdata[7:0];
            REG_WRITE_HOLD: write_hold_ff <= pwdata[9:0];
            REG_WRITE_END:  write_end_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_READ_START: prdata = {22'd0, read_start_ff};
         REG_READ_GAP:   prdata = {24'd0, read_gap_ff};
         REG_WRITE_HOLD: prdata = {22'd0, write_hold_ff};
         REG_WRITE_END:  prdata = {16'd0, write_end_ff};
         default:        prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------
   // One tick. A start seen while idle takes effect in the same tick,
   // so the start decode runs first and the phase step acts on its result.
   // The hold and read end phases are never entered by a start in the same
   // tick, so the bit index and byte count come from the registers.
   // ------------------------------------------------------------------
   assign bit_index = bits_left_ff - 7'd1;
   assign byte_sum  = {1'b0, total_bits_ff} + 8'd7;

   always_comb begin
      phase_in        = phase_ff;
      tick_left_in    = tick_left_ff;
      bits_left_in    = bits_left_ff;
      total_bits_in   = total_bits_ff;
      shift_word_in   = shift_word_ff;
      first_sample_in = first_sample_ff;
      send_word_in    = send_word_ff;
      step_rsp        = '0;

      if (phase_ff == PH_IDLE) begin
         if (req_mode == MODE_READ) begin
            total_bits_in   = (req_bit_count > READ_CAP) ? READ_CAP : req_bit_count;
            bits_left_in    = total_bits_in;
            shift_word_in   = '0;
            first_sample_in = 1'b0;
            tick_left_in    = (read_start_ff == 10'd0) ? 16'd1 : {6'd0, read_start_ff};
            phase_in        = PH_R_START;
         end else if (req_mode == MODE_WRITE) begin
            total_bits_in = '0;
            bits_left_in  = (req_bit_count > WRITE_CAP) ? WRITE_CAP : req_bit_count;
            send_word_in  = req_write_word;
            if (bits_left_in != 7'd0) begin
               phase_in = PH_W_LOW;
            end else begin
               // An empty write still drives at least one low tick.
               phase_in     = PH_W_END;
               tick_left_in = write_end_ff;
            end
         end
      end

      case (phase_in)
         PH_IDLE: begin
            step_rsp.line_drive = DRV_REL;
         end
         PH_R_START: begin
            step_rsp.line_drive = DRV_HIGH;
            if (tick_left_in > 16'd1) begin
               tick_left_in = tick_left_in - 16'd1;
            end else if (bits_left_in != 7'd0) begin
               phase_in = PH_R_LOW;
            end else begin
               phase_in     = PH_R_END;
               tick_left_in = 16'd2;
            end
         end
         PH_R_LOW: begin
            step_rsp.line_drive = DRV_LOW;
            phase_in            = PH_R_HIGH;
         end
         PH_R_HIGH: begin
            step_rsp.line_drive = DRV_HIGH;
            phase_in            = PH_R_SAMP;
         end
         PH_R_SAMP: begin
            first_sample_in = req_line_in;
            tick_left_in    = (read_gap_ff == 8'd0) ? 16'd1 : {8'd0, read_gap_ff};
            phase_in        = PH_R_WAIT;
         end
         PH_R_WAIT: begin
            if (tick_left_in > 16'd1) begin
               tick_left_in = tick_left_in - 16'd1;
            end else begin
               // The bit is one only when both samples saw the wire high.
               shift_word_in = {shift_word_in[ValueW-2:0], req_line_in & first_sample_in};
               if (bits_left_in != 7'd0) begin
                  bits_left_in = bits_left_in - 7'd1;
               end
               if (bits_left_in != 7'd0) begin
                  phase_in = PH_R_LOW;
               end else begin
                  phase_in     = PH_R_END;
                  tick_left_in = 16'd2;
               end
            end
         end
         PH_R_END: begin
            step_rsp.line_drive = DRV_LOW;
            if (tick_left_in > 16'd1) begin
               tick_left_in = tick_left_in - 16'd1;
            end else begin
               step_rsp.done_res   = 1'b1;
               step_rsp.read_value = shift_word_in;
               step_rsp.byte_count = byte_sum[6:3];
               phase_in            = PH_IDLE;
            end
         end
         PH_W_LOW: begin
            step_rsp.line_drive = DRV_LOW;
            phase_in            = PH_W_HIGH;
         end
         PH_W_HIGH: begin
            step_rsp.line_drive = DRV_HIGH;
            tick_left_in = (write_hold_ff == 10'd0) ? 16'd1 : {6'd0, write_hold_ff};
            phase_in     = PH_W_HOLD;
         end
         PH_W_HOLD: begin
            step_rsp.line_drive = send_word_in[bit_index[4:0]] ? DRV_HIGH : DRV_LOW;
            if (tick_left_in > 16'd1) begin
               tick_left_in = tick_left_in - 16'd1;
            end else begin
               if (bits_left_in != 7'd0) begin
                  bits_left_in = bits_left_in - 7'd1;
               end
               if (bits_left_in != 7'd0) begin
                  phase_in = PH_W_LOW;
               end else if (write_end_ff == 16'd0) begin
                  // No end gap: the write finishes on its last hold tick.
                  step_rsp.done_res = 1'b1;
                  phase_in          = PH_IDLE;
               end else begin
                  tick_left_in = write_end_ff;
                  phase_in     = PH_W_END;
               end
            end
         end
         PH_W_END: begin
            step_rsp.line_drive = DRV_LOW;
            if (tick_left_in > 16'd1) begin
               tick_left_in = tick_left_in - 16'd1;
            end else begin
               step_rsp.done_res = 1'b1;
               phase_in          = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      step_rsp.busy_res = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_left_ff  <= '0;
         bits_left_ff  <= '0;
         total_bits_ff <= '0;
      end else if (req_accept) begin
         phase_ff      <= phase_in;
         tick_left_ff  <= tick_left_in;
         bits_left_ff  <= bits_left_in;
         total_bits_ff <= total_bits_in;
      end
      if (req_accept) begin
         shift_word_ff   <= shift_word_in;
         first_sample_ff <= first_sample_in;
         send_word_ff    <= send_word_in;
      end
   end

   // Result register and skid stage.
   pirl_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (step_rsp),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_data  (out_rsp),
      .out_stall (rsp_stall)
   );

   assign rsp_line_drive = out_rsp.line_drive;
   assign rsp_busy_res   = out_rsp.busy_res;
   assign rsp_done_res   = out_rsp.done_res;
   assign rsp_read_value = out_rsp.read_value;
   assign rsp_byte_count = out_rsp.byte_count;

`ifndef SYNTH
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("result beat reports done while still busy");

   a_value_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_read_value == '0 && rsp_byte_count == 4'd0)
      else $error("read value or byte count shown without done");

   a_bits_in_range: assert property (@(posedge clock) disable iff (reset)
      bits_left_ff <= READ_CAP && total_bits_ff <= READ_CAP)
      else $error("bit counter beyond the read limit");

   a_write_bits_capped: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_W_LOW || phase_ff == PH_W_HIGH || phase_ff == PH_W_HOLD)
      |-> bits_left_ff <= WRITE_CAP && bits_left_ff != 7'd0)
      else $error("write bit counter out of range during a write");
`endif

endmodule
